// ===== hdl/grans_pkg.sv =====
// Shared types, constants and helpers for the grouped rANS encoder.
`timescale 1ns / 1ps
package grans_pkg;

  // Command codes carried in s_tuser.
  localparam logic [1:0] CMD_ENCODE = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  // Result kinds carried in m_tuser.
  localparam logic [1:0] KIND_BLOCK = 2'd0;
  localparam logic [1:0] KIND_STATE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_PROB_BITS  = 1'b0;
  localparam logic REG_BLOCK_BITS = 1'b1;

  localparam int MaxBlocks = 33;

  // One stored table entry.
  typedef struct packed {
    logic [7:0]  sub;
    logic [8:0]  size;
    logic [16:0] freq;
    logic [15:0] cdf;
  } entry_t;

  // Write port of the symbol table.
  typedef struct packed {
    logic        en;
    logic        ok;
    logic [7:0]  idx;
    entry_t      data;
  } tbl_wr_t;

  // Saturate prob_bits to 1..16.
  function automatic logic [4:0] sat_prob(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (v == 5'd0) r = 5'd1;
    else if (v > 5'd16) r = 5'd16;
    return r;
  endfunction

  // Saturate block_bits to 1..8.
  function automatic logic [3:0] sat_block(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) r = 4'd1;
    else if (v > 4'd8) r = 4'd8;
    return r;
  endfunction

endpackage

// ===== hdl/grans_table.sv =====
// Symbol table: a synchronous memory of entries plus a valid bit per symbol.
`timescale 1ns / 1ps
module grans_table #(
  parameter int DEPTH = 256,
  parameter int IW    = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  grans_pkg::tbl_wr_t wr,
  input  logic               rd_en,
  input  logic [IW-1:0]      rd_idx,
  output grans_pkg::entry_t  rd_data,
  output logic               rd_valid
);
  import grans_pkg::*;

  entry_t     mem [DEPTH];
  logic [DEPTH-1:0] valid;

  // Entry payload: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx[IW-1:0]] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  // Valid bits are cleared at once by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.idx[IW-1:0]] <= wr.ok;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_idx];
      end
    end
  end

endmodule

// ===== hdl/grans_div.sv =====
// Iterative divider: 24-bit state by 17-bit frequency, four quotient bits a cycle.
`timescale 1ns / 1ps
module grans_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] num,
  input  logic [16:0] den,
  output logic        done,
  output logic [23:0] quo,
  output logic [16:0] rem
);
  import grans_pkg::*;

  logic [2:0]  cnt;
  logic        busy;
  logic [16:0] rem_next;
  logic [23:0] quo_next;

  // Four restoring steps; the dividend shifts out as the quotient shifts in.
  always_comb begin
    logic [17:0] t;
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < 4; i++) begin
      t = {rem_next, quo_next[23]};
      quo_next = {quo_next[22:0], 1'b0};
      if (t >= {1'b0, den}) begin
        t = t - {1'b0, den};
        quo_next[0] = 1'b1;
      end
      rem_next = t[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == 3'd5);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

endmodule

// ===== hdl/grouped_rans_encoder.sv =====
// Top level of the grouped rANS encoder.
`timescale 1ns / 1ps
// The encoder takes one command beat at a time and is busy until its last
// result has been handed to the output register. A load or an ignored command
// finishes when it is accepted; a flush passes through ST_OUT, an error through
// ST_READ and ST_OUT. An encode is accepted, reads the table in ST_READ, then
// runs each coding pass (sub-index pass for groups of more than one symbol,
// then the group pass) through ST_CALC and ST_CHECK, the group pass also
// through ST_DIV, which waits for the four-bit-per-cycle divider; each emitted
// block repeats its pass, and ST_FIN hands over the last block.
// Results leave through an output register, so a block may wait there while
// the next one is computed; a stalled output holds the encoder where it is.
// The symbol table has a valid bit per entry, so no clearing pass follows
// reset.
module grouped_rans_encoder #(
  parameter int ALPHABET = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Command stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // symbol[7:0], entry_group_cdf[23:8], entry_group_freq[40:24],
  // entry_group_size[49:41], entry_sub_index[57:50], zero fill
  input  logic [63:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_tuser,
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_data[23:0]
  output logic [23:0] m_tdata,
  // kind[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import grans_pkg::*;

  localparam int DEPTH = (ALPHABET < 256) ? ALPHABET : 256;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_READ  = 7'b0000010,
    ST_CALC  = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_CHECK = 7'b0010000,
    ST_FIN   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t      st;
  logic [4:0]  prob_bits;
  logic [3:0]  block_bits;
  logic [23:0] coder_state;
  logic        mode;
  logic [5:0]  n_blk;
  logic        pend_v;
  logic [7:0]  pend;
  logic [41:0] ns;
  logic [1:0]  o_kind;
  logic [23:0] o_data;

  // Payload fields.
  logic [7:0]  symbol;
  logic [1:0]  cmd;
  entry_t      in_entry;
  assign symbol        = s_tdata[7:0];
  assign in_entry.cdf  = s_tdata[23:8];
  assign in_entry.freq = s_tdata[40:24];
  assign in_entry.size = s_tdata[49:41];
  assign in_entry.sub  = s_tdata[57:50];
  assign cmd           = s_tuser;

  // Effective parameters.
  logic [4:0]  pb;
  logic [3:0]  bb;
  logic [24:0] smax_w;
  logic [23:0] smax;
  logic [7:0]  bmask;
  logic [23:0] m_val;
  assign pb     = sat_prob(prob_bits);
  assign bb     = sat_block(block_bits);
  assign smax_w = (25'd1 << ({1'b0, pb} + {2'b00, bb})) - 25'd1;
  assign smax   = smax_w[23:0];
  assign bmask  = 8'hFF >> (4'd8 - bb);
  assign m_val  = 24'd1 << pb;

  logic acc, in_range;
  assign s_tready = (st == ST_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign in_range = ({24'd0, symbol} < 32'(ALPHABET));

  // Symbol table.
  tbl_wr_t tw;
  entry_t  ent;
  logic    ent_valid;
  assign tw.en   = acc && (cmd == CMD_LOAD) && in_range;
  assign tw.ok   = (in_entry.freq != 17'd0) && (in_entry.size != 9'd0);
  assign tw.idx  = symbol;
  assign tw.data = in_entry;

  grans_table #(.DEPTH(DEPTH), .IW(IW)) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr       (tw),
    .rd_en    (acc),
    .rd_idx   (symbol[IW-1:0]),
    .rd_data  (ent),
    .rd_valid (ent_valid)
  );

  logic        sym_ok;
  logic        div_start, div_done;
  logic [23:0] div_q;
  logic [16:0] div_r;
  assign div_start = (st == ST_CALC) && mode;

  grans_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (coder_state),
    .den   (ent.freq),
    .done  (div_done),
    .quo   (div_q),
    .rem   (div_r)
  );

  // Configuration access.
  logic cfg_wr;
  logic [4:0] pb_new;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_BLOCK_BITS) ? {28'd0, block_bits} : {27'd0, prob_bits};
  assign pb_new = (paddr[2] == REG_PROB_BITS) ? sat_prob(pwdata[4:0]) : pb;

  logic o_free, emit, o_load;
  assign o_free = !m_tvalid || m_tready;
  assign emit   = (ns > {18'd0, smax}) && (coder_state != 24'd0) && (n_blk < 6'(MaxBlocks));
  // The output register takes a new beat in this cycle.
  assign o_load = o_free && (((st == ST_CHECK) && emit && pend_v) ||
                             ((st == ST_FIN) && pend_v) || (st == ST_OUT));

  // Control sequencer and coder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= ST_IDLE;
      prob_bits   <= 5'd12;
      block_bits  <= 4'd8;
      coder_state <= 24'd4096;
      pend_v      <= 1'b0;
      m_tvalid    <= 1'b0;
      sym_ok      <= 1'b0;
      n_blk       <= '0;
    end else begin
      if (m_tvalid && m_tready && !o_load) m_tvalid <= 1'b0;
      if (cfg_wr) begin
        if (paddr[2] == REG_PROB_BITS) prob_bits <= pwdata[4:0];
        else block_bits <= pwdata[3:0];
        coder_state <= 24'd1 << pb_new;
      end
      unique case (st)
        ST_IDLE: begin
          if (acc) begin
            sym_ok <= in_range;
            n_blk  <= '0;
            if (cmd == CMD_ENCODE) begin
              st <= ST_READ;
            end else if (cmd == CMD_FLUSH) begin
              o_kind      <= KIND_STATE;
              o_data      <= coder_state;
              coder_state <= m_val;
              st          <= ST_OUT;
            end
          end
        end
        ST_READ: begin
          if (!(sym_ok && ent_valid)) begin
            o_kind <= KIND_ERROR;
            o_data <= '0;
            st     <= ST_OUT;
          end else begin
            mode <= (ent.size <= 9'd1);
            st   <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (!mode) begin
            ns <= 42'(coder_state * ent.size) + 42'(ent.sub);
            st <= ST_CHECK;
          end else begin
            st <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            ns <= (42'(div_q) << pb) + 42'(ent.cdf) + 42'(div_r);
            st <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (emit) begin
            if (!pend_v || o_free) begin
              if (pend_v) begin
                m_tvalid <= 1'b1;
                m_tuser  <= KIND_BLOCK;
                m_tdata  <= {16'd0, pend};
                m_tlast  <= 1'b0;
              end
              pend        <= coder_state[7:0] & bmask;
              pend_v      <= 1'b1;
              coder_state <= coder_state >> bb;
              n_blk       <= n_blk + 6'd1;
              st          <= ST_CALC;
            end
          end else begin
            coder_state <= (ns > {18'd0, smax}) ? smax : ns[23:0];
            if (!mode) begin
              mode <= 1'b1;
              st   <= ST_CALC;
            end else begin
              st <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (!pend_v) begin
            st <= ST_IDLE;
          end else if (o_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= KIND_BLOCK;
            m_tdata  <= {16'd0, pend};
            m_tlast  <= 1'b1;
            pend_v   <= 1'b0;
            st       <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (o_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= o_kind;
            m_tdata  <= o_data;
            m_tlast  <= 1'b1;
            st       <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // No block may be held back once the encoder is ready for a new command.
  a_pend_idle: assert property (@(posedge clk) disable iff (rst) s_tready |-> !pend_v)
    else $error("pending block left over at idle");

  // One encode never emits more than the block bound.
  a_blk_bound: assert property (@(posedge clk) disable iff (rst) n_blk <= 6'(MaxBlocks))
    else $error("block count beyond bound");

  // A flush restores the minimum state.
  a_flush: assert property (@(posedge clk) disable iff (rst)
    (acc && cmd == CMD_FLUSH && !cfg_wr) |=> coder_state == m_val)
    else $error("flush did not restore the state");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the grouped rANS encoder: command and result streams with a predictor.
`timescale 1ns / 1ps
module testbench;
  import grans_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 64;

  // One expected or observed result beat.
  typedef struct {
    logic [1:0]  kind;
    logic [23:0] data;
    logic        last;
  } coder_result_t;

  // Predicts coder output from accepted command beats and holds the
  // results still to come.
  class rans_scoreboard;
    logic [4:0]    prob_reg;
    logic [3:0]    block_reg;
    logic [23:0]   coder_x;
    entry_t        tab[256];
    bit            tab_ok[256];
    coder_result_t pending_q[$];
    int            errors;

    function new();
      prob_reg  = 5'd12;
      block_reg = 4'd8;
      coder_x   = 24'd4096;
      errors    = 0;
      foreach (tab_ok[i]) tab_ok[i] = 0;
    endfunction

    function int m_bits();
      if (prob_reg == 0) return 1;
      if (prob_reg > 16) return 16;
      return prob_reg;
    endfunction

    function int b_bits();
      if (block_reg == 0) return 1;
      if (block_reg > 8) return 8;
      return block_reg;
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] value);
      if (addr == 3'd0) prob_reg = value[4:0];
      else if (addr == 3'd4) block_reg = value[3:0];
      else return;
      coder_x = 24'd1 << m_bits();
    endfunction

    // Sub-index coding when grp is 0, group coding when grp is 1.
    function longint unsigned coded(bit grp, longint unsigned x, entry_t e, longint unsigned m);
      if (!grp) return x * e.size + e.sub;
      return (x / e.freq) * m + e.cdf + (x % e.freq);
    endfunction

    // One coding step with renormalisation; returns the updated block count.
    function int coding_pass(bit grp, entry_t e, int n);
      longint unsigned m, smax, bmask, x, nx;
      coder_result_t r;
      m     = 64'd1 << m_bits();
      smax  = (m << b_bits()) - 1;
      bmask = (64'd1 << b_bits()) - 1;
      x     = coder_x;
      nx    = coded(grp, x, e, m);
      while (nx > smax && x != 0 && n < MaxBlocks) begin
        r.kind = KIND_BLOCK;
        r.data = 24'(x & bmask);
        r.last = 1'b0;
        pending_q.insert(pending_q.size(), r);
        n++;
        x  = x >> b_bits();
        nx = coded(grp, x, e, m);
      end
      if (nx > smax) nx = smax;
      coder_x = 24'(nx);
      return n;
    endfunction

    function void note_command(logic [1:0] cmd, logic [63:0] d);
      coder_result_t r;
      entry_t        e;
      int            n;
      logic [7:0]    sym;
      sym = d[7:0];
      n = 0;
      if (cmd == CMD_LOAD) begin
        e.cdf  = d[23:8];
        e.freq = d[40:24];
        e.size = d[49:41];
        e.sub  = d[57:50];
        tab[sym]    = e;
        tab_ok[sym] = (e.freq != 0 && e.size != 0);
      end else if (cmd == CMD_FLUSH) begin
        r.kind = KIND_STATE;
        r.data = coder_x;
        r.last = 1'b1;
        pending_q.insert(pending_q.size(), r);
        coder_x = 24'd1 << m_bits();
      end else if (cmd == CMD_ENCODE) begin
        if (!tab_ok[sym]) begin
          r.kind = KIND_ERROR;
          r.data = '0;
          r.last = 1'b1;
          pending_q.insert(pending_q.size(), r);
        end else begin
          e = tab[sym];
          if (e.size > 1) n = coding_pass(1'b0, e, n);
          n = coding_pass(1'b1, e, n);
          if (n > 0) pending_q[pending_q.size() - 1].last = 1'b1;
        end
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [23:0] data, logic last);
      coder_result_t r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result kind %0d data %0h last %0d", $time, kind, data, last);
        errors++;
        return;
      end
      r = pending_q.pop_front();
      if (kind !== r.kind) begin
        $display("%0t: kind mismatch: expected %0d, got %0d", $time, r.kind, kind);
        errors++;
      end
      if (data !== r.data) begin
        $display("%0t: data mismatch: expected %0h, got %0h", $time, r.data, data);
        errors++;
      end
      if (last !== r.last) begin
        $display("%0t: last mismatch: expected %0d, got %0d", $time, r.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rans_scoreboard sb;
  int idle_pct;
  int stall_pct;
  int cycles = 0;

  grouped_rans_encoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side: random stalls chosen at each falling edge.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sends one command beat, with an optional random gap before it.
  task automatic send_beat(logic [1:0] cmd, logic [63:0] d);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = d;
    do @(posedge clk); while (!s_tready);
    sb.note_command(cmd, d);
  endtask

  function automatic logic [63:0] pack_entry(logic [7:0] sym, logic [15:0] cdf,
                                             logic [16:0] freq, logic [8:0] size,
                                             logic [7:0] sub);
    return {6'd0, sub, size, freq, cdf, sym};
  endfunction

  // Holds the command stream until every expected result has come.
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Register write through the configuration port, only when idle.
  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    drain();
    psel   = 1'b1;
    pwrite = 1'b1;
    paddr  = addr;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    sb.write_reg(addr, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Random traffic for one setting: a consistent table, then mostly encodes.
  task automatic random_phase(int count);
    int mb, f, c, sz;
    logic [7:0] sym;
    mb = sb.m_bits();
    for (int i = 0; i < 8; i++) begin
      f  = $urandom_range(1 << mb, 1);
      c  = $urandom_range((1 << mb) - f, 0);
      sz = ($urandom_range(1)) ? 1 : $urandom_range(256, 2);
      send_beat(CMD_LOAD, pack_entry(8'($urandom_range(15)), 16'(c), 17'(f), 9'(sz),
                                     8'($urandom_range(sz - 1))));
    end
    for (int i = 0; i < count; i++) begin
      sym = 8'($urandom_range(15));
      case ($urandom_range(19))
        0:       send_beat(CMD_FLUSH, {56'd0, sym});
        1:       send_beat(2'($urandom_range(3)), {$urandom, $urandom});
        2:       send_beat(CMD_ENCODE, {56'd0, 8'($urandom)});
        default: send_beat(CMD_ENCODE, {56'd0, sym});
      endcase
      if (i == count / 2 && $urandom_range(1)) drain();
    end
    send_beat(CMD_FLUSH, 64'd0);
  endtask

  initial begin
    sb = new();
    idle_pct  = 0;
    stall_pct = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_ENCODE;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset setting.
    send_beat(CMD_ENCODE, 64'd0);
    send_beat(2'd3, {$urandom, $urandom});
    send_beat(CMD_LOAD, pack_entry(8'd0, 16'd0, 17'd1024, 9'd4, 8'd3));
    send_beat(CMD_LOAD, pack_entry(8'd255, 16'hFFFF, 17'h10000, 9'h1FF, 8'hFF));
    send_beat(CMD_LOAD, pack_entry(8'd1, 16'd5, 17'd0, 9'd1, 8'd0));
    send_beat(CMD_LOAD, pack_entry(8'd2, 16'd5, 17'd7, 9'd0, 8'd0));
    send_beat(CMD_LOAD, pack_entry(8'd3, 16'd1024, 17'd3072, 9'd1, 8'd0));
    send_beat(CMD_LOAD, pack_entry(8'd4, 16'd4095, 17'd1, 9'd256, 8'd128));
    for (int i = 0; i < 3; i++) begin
      send_beat(CMD_ENCODE, 64'd0);
      send_beat(CMD_ENCODE, 64'd3);
      send_beat(CMD_ENCODE, 64'd4);
    end
    send_beat(CMD_ENCODE, 64'd1);
    send_beat(CMD_ENCODE, 64'd2);
    send_beat(CMD_ENCODE, 64'd255);
    send_beat(CMD_FLUSH, 64'd0);
    send_beat(CMD_FLUSH, 64'd0);

    // Random part over several settings and idling and stall phases.
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      case (p)
        1: begin write_reg(3'd0, 32'd1);  write_reg(3'd4, 32'd1);  end
        2: begin write_reg(3'd0, 32'd16); write_reg(3'd4, 32'd8);  end
        3: begin write_reg(3'd0, 32'd0);  write_reg(3'd4, 32'd0);  end
        4: begin write_reg(3'd0, 32'd31); write_reg(3'd4, 32'd15); end
        5: begin write_reg(3'd0, 32'd5);  write_reg(3'd4, 32'd3);  end
        6: begin write_reg(3'd0, 32'd10); write_reg(3'd4, 32'd4);  end
        7: begin write_reg(3'd0, 32'd16); write_reg(3'd4, 32'd1);  end
        default: ;
      endcase
      random_phase(10);
    end

    drain();
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/grans_pkg.sv
hdl/grans_table.sv
hdl/grans_div.sv
hdl/grouped_rans_encoder.sv
tb/testbench.sv
